FILE: hdl/ssel_pkg.sv
// shared types and constants for the safety sensor emergency latch
package ssel_pkg;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned TIME_W     = 32;

    // register indexes (byte address is 4 times the index)
    localparam logic [2:0] REG_STOP_HOLD   = 3'd0;
    localparam logic [2:0] REG_ONE_WHEEL   = 3'd1;
    localparam logic [2:0] REG_BOTH_WHEELS = 3'd2;
    localparam logic [2:0] REG_TILT_HOLD   = 3'd3;
    localparam logic [2:0] REG_CLEAR_HOLD  = 3'd4;
    localparam logic [2:0] REG_ALARM_PER   = 3'd5;

    localparam logic [HOLD_W-1:0] RST_STOP_HOLD   = 16'd20;
    localparam logic [HOLD_W-1:0] RST_ONE_WHEEL   = 16'd1000;
    localparam logic [HOLD_W-1:0] RST_BOTH_WHEELS = 16'd100;
    localparam logic [HOLD_W-1:0] RST_TILT_HOLD   = 16'd500;
    localparam logic [HOLD_W-1:0] RST_CLEAR_HOLD  = 16'd2000;
    localparam logic [HOLD_W-1:0] RST_ALARM_PER   = 16'd5000;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic [1:0] CHIRP_NONE  = 2'd0;
    localparam logic [1:0] CHIRP_CLEAR = 2'd1;
    localparam logic [1:0] CHIRP_ALARM = 2'd2;

    localparam logic [7:0] BIT_YELLOW = 8'h02;
    localparam logic [7:0] BIT_WHITE  = 8'h04;
    localparam logic [7:0] BIT_BLUE   = 8'h08;
    localparam logic [7:0] BIT_RED    = 8'h10;
    localparam logic [7:0] BIT_BOTH   = 8'h18;
    localparam logic [7:0] BIT_TILT   = 8'h20;

    typedef struct packed {
        logic              opcode;
        logic              yellow_stop;
        logic              white_stop;
        logic              blue_lift;
        logic              red_lift;
        logic              mech_tilt;
        logic              accel_tilt;
        logic              play_pressed;
        logic [TIME_W-1:0] now_ms;
        logic [7:0]        state_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] emergency_bits;
        logic [1:0] chirp;
    } t_out_item;

    typedef struct packed {
        logic [HOLD_W-1:0] stop_hold_ms;
        logic [HOLD_W-1:0] one_wheel_hold_ms;
        logic [HOLD_W-1:0] both_wheels_hold_ms;
        logic [HOLD_W-1:0] tilt_hold_ms;
        logic [HOLD_W-1:0] clear_hold_ms;
        logic [HOLD_W-1:0] alarm_period_ms;
    } t_cfg;

    typedef struct packed {
        logic              fire;
        logic [TIME_W-1:0] start;
    } t_hold;

endpackage

FILE: hdl/ssel_cfg.sv
// apb register file holding the hold times and alarm period
module ssel_cfg
    import ssel_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_STOP_HOLD:   n_cfg.stop_hold_ms        = pwdata[HOLD_W-1:0];
                REG_ONE_WHEEL:   n_cfg.one_wheel_hold_ms   = pwdata[HOLD_W-1:0];
                REG_BOTH_WHEELS: n_cfg.both_wheels_hold_ms = pwdata[HOLD_W-1:0];
                REG_TILT_HOLD:   n_cfg.tilt_hold_ms        = pwdata[HOLD_W-1:0];
                REG_CLEAR_HOLD:  n_cfg.clear_hold_ms       = pwdata[HOLD_W-1:0];
                REG_ALARM_PER:   n_cfg.alarm_period_ms     = pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STOP_HOLD:   prdata = {16'd0, r_cfg.stop_hold_ms};
            REG_ONE_WHEEL:   prdata = {16'd0, r_cfg.one_wheel_hold_ms};
            REG_BOTH_WHEELS: prdata = {16'd0, r_cfg.both_wheels_hold_ms};
            REG_TILT_HOLD:   prdata = {16'd0, r_cfg.tilt_hold_ms};
            REG_CLEAR_HOLD:  prdata = {16'd0, r_cfg.clear_hold_ms};
            REG_ALARM_PER:   prdata = {16'd0, r_cfg.alarm_period_ms};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_hold_ms        <= RST_STOP_HOLD;
            r_cfg.one_wheel_hold_ms   <= RST_ONE_WHEEL;
            r_cfg.both_wheels_hold_ms <= RST_BOTH_WHEELS;
            r_cfg.tilt_hold_ms        <= RST_TILT_HOLD;
            r_cfg.clear_hold_ms       <= RST_CLEAR_HOLD;
            r_cfg.alarm_period_ms     <= RST_ALARM_PER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: hdl/ssel_core.sv
// condition timers, sticky emergency bits, clear and alarm chirps
module ssel_core
    import ssel_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [7:0]        r_emerg;
    logic [TIME_W-1:0] r_stop_start;
    logic [TIME_W-1:0] r_both_start;
    logic [TIME_W-1:0] r_blue_start;
    logic [TIME_W-1:0] r_red_start;
    logic [TIME_W-1:0] r_accel_start;
    logic [TIME_W-1:0] r_tilt_start;
    logic [TIME_W-1:0] r_clear_start;
    logic [TIME_W-1:0] r_last_alarm;

    logic [7:0]        n_emerg;
    logic [TIME_W-1:0] n_stop_start;
    logic [TIME_W-1:0] n_both_start;
    logic [TIME_W-1:0] n_blue_start;
    logic [TIME_W-1:0] n_red_start;
    logic [TIME_W-1:0] n_accel_start;
    logic [TIME_W-1:0] n_tilt_start;
    logic [TIME_W-1:0] n_clear_start;
    logic [TIME_W-1:0] n_last_alarm;

    t_hold             h_stop, h_both, h_blue, h_red, h_accel, h_tilt, h_clear;
    logic [7:0]        set_bits;
    logic [TIME_W-1:0] alarm_gap;
    logic [1:0]        chirp;

    // zero start means idle, so a start at tick zero restarts next poll
    function automatic t_hold hold_check(input logic              active,
                                         input logic [TIME_W-1:0] start,
                                         input logic [TIME_W-1:0] now,
                                         input logic [HOLD_W-1:0] hold);
        t_hold             h;
        logic [TIME_W-1:0] diff;
        diff = now - start;
        h.fire  = 1'b0;
        h.start = start;
        if (!active) begin
            h.start = '0;
        end else if (start == '0) begin
            h.start = now;
        end else begin
            h.fire = (diff >= {{(TIME_W-HOLD_W){1'b0}}, hold});
        end
        return h;
    endfunction

    always_comb begin
        h_stop  = hold_check(i_item.yellow_stop || i_item.white_stop, r_stop_start,
                             i_item.now_ms, i_cfg.stop_hold_ms);
        h_both  = hold_check(i_item.blue_lift && i_item.red_lift, r_both_start,
                             i_item.now_ms, i_cfg.both_wheels_hold_ms);
        h_blue  = hold_check(i_item.blue_lift, r_blue_start,
                             i_item.now_ms, i_cfg.one_wheel_hold_ms);
        h_red   = hold_check(i_item.red_lift, r_red_start,
                             i_item.now_ms, i_cfg.one_wheel_hold_ms);
        h_accel = hold_check(i_item.accel_tilt, r_accel_start,
                             i_item.now_ms, i_cfg.tilt_hold_ms);
        h_tilt  = hold_check(i_item.mech_tilt, r_tilt_start,
                             i_item.now_ms, i_cfg.tilt_hold_ms);

        set_bits = r_emerg;
        if (h_stop.fire && i_item.yellow_stop) set_bits = set_bits | BIT_YELLOW;
        if (h_stop.fire && i_item.white_stop)  set_bits = set_bits | BIT_WHITE;
        if (h_both.fire)  set_bits = set_bits | BIT_BOTH;
        if (h_blue.fire)  set_bits = set_bits | BIT_BLUE;
        if (h_red.fire)   set_bits = set_bits | BIT_RED;
        if (h_accel.fire || h_tilt.fire) set_bits = set_bits | BIT_TILT;

        // play hold is only armed while some bit stands after this poll's sets
        h_clear = hold_check((set_bits != 8'd0) && i_item.play_pressed, r_clear_start,
                             i_item.now_ms, i_cfg.clear_hold_ms);

        n_emerg      = set_bits;
        chirp        = CHIRP_NONE;
        n_last_alarm = r_last_alarm;
        if (h_clear.fire) begin
            n_emerg = 8'd0;
            chirp   = CHIRP_CLEAR;
        end

        alarm_gap = i_item.now_ms - r_last_alarm;
        if ((n_emerg != 8'd0) &&
            (alarm_gap > {{(TIME_W-HOLD_W){1'b0}}, i_cfg.alarm_period_ms})) begin
            n_last_alarm = i_item.now_ms;
            chirp        = CHIRP_ALARM;
        end

        n_stop_start  = h_stop.start;
        n_both_start  = h_both.start;
        n_blue_start  = h_blue.start;
        n_red_start   = h_red.start;
        n_accel_start = h_accel.start;
        n_tilt_start  = h_tilt.start;
        n_clear_start = h_clear.start;

        // set-state item overwrites the bits and leaves all timers alone
        if (i_item.opcode == OP_SET) begin
            n_emerg       = i_item.state_value;
            chirp         = CHIRP_NONE;
            n_last_alarm  = r_last_alarm;
            n_stop_start  = r_stop_start;
            n_both_start  = r_both_start;
            n_blue_start  = r_blue_start;
            n_red_start   = r_red_start;
            n_accel_start = r_accel_start;
            n_tilt_start  = r_tilt_start;
            n_clear_start = r_clear_start;
        end

        o_result.emergency_bits = n_emerg;
        o_result.chirp          = chirp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emerg       <= '0;
            r_stop_start  <= '0;
            r_both_start  <= '0;
            r_blue_start  <= '0;
            r_red_start   <= '0;
            r_accel_start <= '0;
            r_tilt_start  <= '0;
            r_clear_start <= '0;
            r_last_alarm  <= '0;
        end else if (i_go) begin
            r_emerg       <= n_emerg;
            r_stop_start  <= n_stop_start;
            r_both_start  <= n_both_start;
            r_blue_start  <= n_blue_start;
            r_red_start   <= n_red_start;
            r_accel_start <= n_accel_start;
            r_tilt_start  <= n_tilt_start;
            r_clear_start <= n_clear_start;
            r_last_alarm  <= n_last_alarm;
        end
    end

endmodule

FILE: hdl/safety_sensor_emergency_latch_top.sv
// top level: input register, latch core, result register and config port
//
// Poll items enter on the input channel (i_in_valid, i_in_item, o_in_stall)
// and each one gives exactly one result item on the output channel
// (o_out_valid, o_out_item, i_out_stall). An item is taken at a clock edge
// with valid high and stall low.
// Each item passes through the input register, then the core's timer compares
// and bit updates, then the result register. Throughput is one item per
// cycle while the output is not stalled, as the timer and emergency state
// update as each item moves into the result register.
// A stalled result holds in the result register while the input register
// still takes one more item; o_in_stall rises only when both are full.
// Synchronous reset (i_rst_n low) empties both registers, clears the
// emergency bits, all condition timers and the last alarm time, and loads
// the default hold times. The APB port (psel, penable, pwrite, paddr,
// pwdata, prdata, pready) writes and reads the six 16-bit registers at byte
// addresses 0 to 20; pready is always high. Write only while idle.
module safety_sensor_emergency_latch_top
    import ssel_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  logic                  i_out_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      n_in_valid;
    logic      n_out_valid;

    logic      in_take;
    logic      go;
    t_cfg      cfg;
    t_out_item result;

    assign go          = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !go;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (go) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (go) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    ssel_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ssel_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (go) begin
            r_out_item <= result;
        end
    end

endmodule
